FILE: rtl/fir_lp_pkg.sv
package fir_lp_pkg;

  localparam int TAP_COUNT   = 39;
  localparam int SAMPLE_BITS = 16;
  localparam int ROM_TAPS    = 39;
  localparam int COEF_BITS   = 16;
  localparam int ACC_BITS    = 40;
  localparam int FRAC_BITS   = 15;

  localparam int TDATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int IDX_BITS     = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int ROM_IDX_BITS = $clog2(ROM_TAPS);
  localparam int WIDE_BITS    = (IDX_BITS > ROM_IDX_BITS) ? IDX_BITS : ROM_IDX_BITS;
  localparam int PROD_BITS    = SAMPLE_BITS + COEF_BITS;
  localparam int Q_BITS       = ACC_BITS - FRAC_BITS;

  typedef logic [IDX_BITS-1:0]          tap_idx_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;

  // Q1.15 low-pass taps, symmetric
  localparam coef_t COEF_ROM [0:ROM_TAPS-1] = '{
    -16'sd21, -16'sd14, -16'sd4, 16'sd12, 16'sd42, 16'sd91, 16'sd164, 16'sd264,
    16'sd394, 16'sd553, 16'sd738, 16'sd944, 16'sd1162, 16'sd1384, 16'sd1597,
    16'sd1791, 16'sd1955, 16'sd2080, 16'sd2158, 16'sd2185, 16'sd2158, 16'sd2080,
    16'sd1955, 16'sd1791, 16'sd1597, 16'sd1384, 16'sd1162, 16'sd944, 16'sd738,
    16'sd553, 16'sd394, 16'sd264, 16'sd164, 16'sd91, 16'sd42, 16'sd12, -16'sd4,
    -16'sd14, -16'sd21
  };

  // taps past the end of the table are zero
  function automatic coef_t coef_lookup(input tap_idx_t idx);
    logic [WIDE_BITS-1:0] wide_idx;
    wide_idx = WIDE_BITS'(idx);
    if (wide_idx < WIDE_BITS'(ROM_TAPS)) begin
      return COEF_ROM[wide_idx[ROM_IDX_BITS-1:0]];
    end
    return '0;
  endfunction

  typedef struct packed {
    logic     shift_in;
    logic     rotate;
    tap_idx_t tap_idx;
    logic     clear_acc;
    logic     emit;
  } fir_cmd_t;

  typedef struct packed {
    logic busy;
  } fir_stat_t;

endpackage

FILE: rtl/fir_lp_datapath.sv
module fir_lp_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  fir_lp_pkg::sample_t             sample_in,
  input  fir_lp_pkg::fir_cmd_t            cmd,
  output fir_lp_pkg::fir_stat_t           stat,
  output fir_lp_pkg::sample_t             sample_out
);
  import fir_lp_pkg::*;

  localparam logic signed [Q_BITS-1:0] SAT_HI =
    Q_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [Q_BITS-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
    ACC_BITS'(64'sd1 <<< (FRAC_BITS - 1));

  sample_t delay_line [0:TAP_COUNT-1];

  sample_t                      samp_r;
  coef_t                        coef_r;
  logic                         v1;
  logic signed [PROD_BITS-1:0]  prod;
  logic                         v2;
  logic signed [ACC_BITS-1:0]   acc;

  logic signed [ACC_BITS-1:0]   biased;
  logic signed [Q_BITS-1:0]     q;
  sample_t                      sat;

  // delay line: new sample enters at the head, rotation recirculates the tail
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAP_COUNT; i++) begin
        delay_line[i] <= '0;
      end
    end else if (cmd.shift_in || cmd.rotate) begin
      delay_line[0] <= cmd.shift_in ? sample_in : delay_line[TAP_COUNT-1];
      for (int i = 1; i < TAP_COUNT; i++) begin
        delay_line[i] <= delay_line[i-1];
      end
    end
  end

  // mac pipeline: operand fetch, multiply, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.rotate;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rotate) begin
      samp_r <= delay_line[TAP_COUNT-1];
      coef_r <= coef_lookup(cmd.tap_idx);
    end
    if (v1) begin
      prod <= samp_r * coef_r;
    end
    if (cmd.clear_acc) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + {{(ACC_BITS-PROD_BITS){prod[PROD_BITS-1]}}, prod};
    end
  end

  // round half up, then clamp
  always_comb begin
    biased = acc + ROUND_HALF;
    q      = biased[ACC_BITS-1:FRAC_BITS];
    if (q > SAT_HI) begin
      sat = sample_t'(SAT_HI);
    end else if (q < SAT_LO) begin
      sat = sample_t'(SAT_LO);
    end else begin
      sat = q[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sample_out <= sat;
    end
  end

  assign stat.busy = v1 | v2;

endmodule

FILE: rtl/fir_lp_ctrl.sv
module fir_lp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  fir_lp_pkg::fir_stat_t stat,
  output fir_lp_pkg::fir_cmd_t  cmd
);
  import fir_lp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t   state;
  tap_idx_t tap_idx;
  logic     out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd           = '0;
    cmd.tap_idx   = tap_idx;
    cmd.shift_in  = (state == S_IDLE) && in_valid;
    cmd.clear_acc = (state == S_IDLE) && in_valid;
    cmd.rotate    = (state == S_RUN);
    cmd.emit      = (state == S_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tap_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            tap_idx <= tap_idx_t'(TAP_COUNT - 1);
            state   <= S_RUN;
          end
        end
        S_RUN: begin
          if (tap_idx == '0) begin
            state <= S_DRAIN;
          end else begin
            tap_idx <= tap_idx - 1'b1;
          end
        end
        S_DRAIN: begin
          if (!stat.busy) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/fir_lowpass_39tap.sv
// 39-tap symmetric low-pass fir for 48 kHz audio, one shared multiply-accumulate
//
// input stream (s_axis_*): one signed sample per word, accepted when tvalid and
// tready are high together. tready is high only while the filter is idle.
// output stream (m_axis_*): one filtered sample per input sample, rounded half
// up from q.15 and clamped to the signed sample range.
//
// each word goes from acceptance to tvalid on the output in these steps: the
// sample enters the delay line at the accepting edge, then the delay line
// rotates past the single multiplier one tap at a time, the multiply and
// accumulate stages drain, the controller sees the pipeline empty, and round
// and saturate write the result into the output register.
// the tap loop through the one multiplier sets the rate: a new word is taken
// only once the last one's result is registered, and later if the receiver
// stalls, since tready comes back as the result enters the output register.
//
// the output word sits in a register; a new input word is accepted while it
// waits. if the receiver stalls, the next result holds inside until the
// register is free, and no further input is taken meanwhile.
// reset (rst, synchronous) clears the delay line to zero and empties the output.
module fir_lowpass_39tap (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [fir_lp_pkg::TDATA_BITS-1:0]   s_axis_tdata,   // sample_in
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [fir_lp_pkg::TDATA_BITS-1:0]   m_axis_tdata    // sample_out
);
  import fir_lp_pkg::*;

  fir_cmd_t  cmd;
  fir_stat_t stat;
  sample_t   sample_in;
  sample_t   sample_out;

  // bits above the sample width are ignored
  assign sample_in = s_axis_tdata[SAMPLE_BITS-1:0];

  fir_lp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fir_lp_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (sample_in),
    .cmd        (cmd),
    .stat       (stat),
    .sample_out (sample_out)
  );

  // zero fill up to whole bytes
  assign m_axis_tdata = TDATA_BITS'($unsigned(sample_out));

endmodule
